// ===== src/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Payload types, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       message_end;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } sha_state_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== src/sha_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs 64 rounds, one per cycle, over a block read from the byte buffer.
// The message schedule lives in a 16-word sliding window of registers.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] load_word,
  input  logic        load_en,
  input  logic [31:0] hash_in [8],
  output logic [31:0] hash_out [8],
  output logic        done
);
  import sha_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic [31:0] w_cur, w_new, s0w, s1w, t1, t2, sum1, sum0, ch, maj;

  // schedule and round functions: next word from the window, T1 and T2
  always_comb begin
    s0w   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1w   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = s1w + w_r[9] + s0w + w_r[0];
    w_cur = w_r[0];
    sum1  = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sum0  = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sum1 + ch + round_k(rnd_r) + w_cur;
    t2    = sum0 + maj;
  end

  // load shifts words in; rounds shift the window
  always_ff @(posedge clk) begin
    if (load_en || busy_r) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= load_en ? load_word : w_new;
    end
    if (start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= hash_in[i];
    end else if (busy_r) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // round counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
    end else if (busy_r) begin
      rnd_r <= rnd_r + 6'd1;
      if (rnd_r == 6'd63) busy_r <= 1'b0;
    end
  end

  assign done = busy_r && (rnd_r == 6'd63);

  always_comb begin
    hash_out[0] = hash_in[0] + t1 + t2;
    hash_out[4] = hash_in[4] + v_r[3] + t1;
    hash_out[1] = hash_in[1] + v_r[0];
    hash_out[2] = hash_in[2] + v_r[1];
    hash_out[3] = hash_in[3] + v_r[2];
    hash_out[5] = hash_in[5] + v_r[4];
    hash_out[6] = hash_in[6] + v_r[5];
    hash_out[7] = hash_in[7] + v_r[6];
  end
endmodule

// ===== src/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Buffers bytes in a 64-byte memory, compresses full blocks, pads at the
// end mark and emits the digest as four 64-bit beats.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | input     | sha_in_t  (data_byte, byte_valid, message_end)
//  out_    | output    | sha_out_t (digest_word, word_index, last_word)
//
// A byte that does not fill a block is written to the buffer and the input stays
// ready for the next. A full block streams 64 bytes from the buffer into the
// schedule, then runs 64 rounds on the single round unit.
// An end mark pads through the buffer port (one byte per cycle), runs one or
// two blocks, then presents four beats. Reset is synchronous and needs no
// clearing pass. The input stalls while a block or digest is in progress.
module sha256_byte_stream_hasher (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sha_pkg::sha_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  logic [7:0]  buf_mem [64];
  logic [7:0]  rd_data_r;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [5:0]  rd_addr;

  sha_state_t  state_r, state_nxt;
  logic [31:0] hash_r [8];
  logic [31:0] hash_new [8];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        end_r, end_nxt;
  logic        pad_done_r, pad_done_nxt;
  logic        mark_r, mark_nxt;
  logic [31:0] word_r;
  logic [1:0]  idx_r, idx_nxt;
  logic        core_start, core_load, core_done;
  logic        hash_upd, hash_init;

  // byte buffer memory
  always_ff @(posedge clk) begin
    if (wr_en) buf_mem[wr_addr] <= wr_data;
    rd_data_r <= buf_mem[rd_addr];
  end

  // assemble big-endian words from read bytes
  always_ff @(posedge clk) begin
    word_r <= {word_r[23:0], rd_data_r};
  end

  sha_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (core_start),
    .load_word(word_r),
    .load_en  (core_load),
    .hash_in  (hash_r),
    .hash_out (hash_new),
    .done     (core_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      bits_r     <= '0;
      cnt_r      <= '0;
      end_r      <= 1'b0;
      pad_done_r <= 1'b0;
      mark_r     <= 1'b0;
      idx_r      <= '0;
      for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bits_r     <= bits_nxt;
      cnt_r      <= cnt_nxt;
      end_r      <= end_nxt;
      pad_done_r <= pad_done_nxt;
      mark_r     <= mark_nxt;
      idx_r      <= idx_nxt;
      if (hash_init) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= init_hash(3'(i));
      end else if (hash_upd) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_new[i];
      end
    end
  end

  // sequencer: absorb, load block, rounds, pad, emit
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    end_nxt      = end_r;
    pad_done_nxt = pad_done_r;
    mark_nxt     = mark_r;
    idx_nxt      = idx_r;
    in_ready     = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = fill_r;
    wr_data      = in_data.data_byte;
    rd_addr      = cnt_r[5:0];
    core_start   = 1'b0;
    core_load    = 1'b0;
    hash_upd     = 1'b0;
    hash_init    = 1'b0;
    out_valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          end_nxt = in_data.message_end;
          pad_done_nxt = 1'b0;
          mark_nxt = 1'b0;
          if (in_data.byte_valid) begin
            wr_en    = 1'b1;
            bits_nxt = bits_r + 64'd8;
            fill_nxt = fill_r + 6'd1;
          end
          if (in_data.byte_valid && fill_r == 6'd63) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else if (in_data.message_end) begin
            cnt_nxt   = '0;
            state_nxt = ST_PAD;
          end
        end
      end
      // write pad bytes from fill position to 63
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_addr = fill_r;
        mark_nxt = 1'b1;
        if (!pad_done_r && cnt_r == 7'd0) wr_data = PadByte;
        else if (fill_r >= 6'd56 && pad_done_r) wr_data = bits_r[8*(63-fill_r) +: 8];
        else wr_data = 8'h00;
        cnt_nxt  = 7'd1;
        fill_nxt = fill_r + 6'd1;
        if (fill_r == 6'd63) begin
          // length fits only if the marker landed before byte 56
          if (!pad_done_r && cnt_r == 7'd0) pad_done_nxt = 1'b0;
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
        end else if (!pad_done_r && fill_r == 6'd55) begin
          pad_done_nxt = 1'b1;
        end
      end
      // stream 64 bytes into the schedule window
      ST_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r >= 7'd5 && cnt_r[1:0] == 2'd1) core_load = 1'b1;
        if (cnt_r == 7'd65) begin
          core_start = 1'b1;
          state_nxt  = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (core_done) begin
          hash_upd = 1'b1;
          fill_nxt = '0;
          if (!end_r) begin
            state_nxt = ST_IDLE;
          end else if (!pad_done_r) begin
            // start with the marker unless it already went into the last block
            cnt_nxt   = mark_r ? 7'd1 : 7'd0;
            state_nxt = ST_PAD;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            hash_init    = 1'b1;
            bits_nxt     = '0;
            fill_nxt     = '0;
            end_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_data.digest_word = {hash_r[{idx_r, 1'b0}], hash_r[{idx_r, 1'b1}]};
    out_data.word_index  = idx_r;
    out_data.last_word   = (idx_r == 2'd3);
  end
endmodule

// ===== src/sha_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Watches the digest beats and the input ready on the top-level ports.
// ----------------------------------------------------------------------------
module sha_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("digest beat changed while stalled");

  // last flag marks index three only
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 2'd3)))
    else $error("last_word mismatch");

  // beats advance in order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_word |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1)
    else $error("digest beats out of order");

  // no input taken while emitting
  a_no_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted during digest");
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
